// ===== src/ets_pkg.sv =====
// Shared types and constants for the Taylor-series exponential block.
`timescale 1ns / 1ps

package ets_pkg;

    localparam int FRAC_BITS_DEFAULT  = 20;
    localparam int REF_FRAC           = 20;
    localparam int X_FRAC             = 16;
    localparam int X_W                = 20;
    localparam int EPS_W              = 20;
    localparam int CAP_W              = 7;
    localparam int EXP_W              = 32;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 20;
    localparam int DIV_BITS_PER_CYCLE = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMS = 2'd1;

    localparam logic [EPS_W-1:0] EPSILON_RESET   = 20'd1049;
    localparam logic [CAP_W-1:0] MAX_TERMS_RESET = 7'd40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_FINAL,
        ST_OUT
    } ets_state_t;

endpackage

// ===== src/exp_taylor_series.sv =====
// Top level of the Taylor-series exponential: sequencer, multiplier, accumulator and outputs.
// Each series term passes through the MUL, DIV_LOAD and DIV_WAIT states, the last waiting on the
// shared multi-bit divider; after the last term, FINAL registers the result and OUT holds out_valid,
// and the next item is taken in the cycle after the result transfer.
// The block handles one item at a time and holds in_stall high while it works.
// Reset returns the sequencer to idle and sets epsilon to 1049 and max_terms to 40.
`timescale 1ns / 1ps

module exp_taylor_series #(
    parameter int FRAC_BITS = ets_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ets_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ets_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ets_pkg::X_W-1:0]      x_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ets_pkg::EXP_W-1:0]           exp_value,
    output logic [ets_pkg::CAP_W-1:0]           terms_used,
    output logic                                hit_cap
);

    localparam int TERM_W  = FRAC_BITS + 11;
    localparam int SUM_W   = FRAC_BITS + 14;
    localparam int PROD_W  = TERM_W + ets_pkg::X_W;
    localparam int DIV_W   = PROD_W - ets_pkg::X_FRAC;
    localparam int OUT_W   = SUM_W + 8;
    localparam int EPS_SHL = (FRAC_BITS >= ets_pkg::REF_FRAC) ? FRAC_BITS - ets_pkg::REF_FRAC : 0;
    localparam int EPS_SHR = (FRAC_BITS < ets_pkg::REF_FRAC) ? ets_pkg::REF_FRAC - FRAC_BITS : 0;
    localparam int CAP_W   = ets_pkg::CAP_W;
    localparam int EXP_W   = ets_pkg::EXP_W;
    localparam int EPS_W   = ets_pkg::EPS_W;

    localparam logic signed [TERM_W-1:0] TERM_ONE = TERM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0]  SUM_ONE  = SUM_W'(1) << FRAC_BITS;

    ets_pkg::ets_state_t state_reg;
    ets_pkg::ets_state_t state_next;

    logic [EPS_W-1:0]          epsilon_reg;
    logic [EPS_W-1:0]          epsilon_next;
    logic [CAP_W-1:0]          max_terms_reg;
    logic [CAP_W-1:0]          max_terms_next;

    logic signed [ets_pkg::X_W-1:0] x_reg;
    logic signed [ets_pkg::X_W-1:0] x_next;
    logic signed [TERM_W-1:0]  term_reg;
    logic signed [TERM_W-1:0]  term_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic [CAP_W-1:0]          used_reg;
    logic [CAP_W-1:0]          used_next;
    logic                      cap_reg;
    logic                      cap_next;
    logic [EXP_W-1:0]          exp_value_reg;
    logic [EXP_W-1:0]          exp_value_next;
    logic [CAP_W-1:0]          terms_used_reg;
    logic [CAP_W-1:0]          terms_used_next;
    logic                      hit_cap_reg;
    logic                      hit_cap_next;

    logic [TERM_W-1:0]         eps_int;
    logic [PROD_W-1:0]         prod_mag;
    logic                      prod_neg;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quot;
    logic [TERM_W-1:0]         quot;
    logic signed [SUM_W-1:0]   quot_ext;
    logic [OUT_W-1:0]          sum_wide;
    logic [OUT_W-1:0]          sum_scaled;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ets_pkg::ST_IDLE);
    assign out_valid = (state_reg == ets_pkg::ST_OUT);
    assign exp_value  = exp_value_reg;
    assign terms_used = terms_used_reg;
    assign hit_cap    = hit_cap_reg;

    assign eps_int    = (TERM_W'(epsilon_reg) << EPS_SHL) >> EPS_SHR;
    assign prod_neg   = prod_reg[PROD_W-1];
    assign prod_mag   = prod_neg ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign quot       = div_quot[TERM_W-1:0];
    assign quot_ext   = SUM_W'(quot);
    assign sum_wide   = OUT_W'($unsigned(sum_reg));
    assign sum_scaled = (sum_wide << EPS_SHR) >> EPS_SHL;

    ets_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CAP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[PROD_W-1:ets_pkg::X_FRAC]),
        .divisor  (CAP_W'(used_reg + CAP_W'(1))),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ets_pkg::ST_IDLE;
            epsilon_reg   <= ets_pkg::EPSILON_RESET;
            max_terms_reg <= ets_pkg::MAX_TERMS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            epsilon_reg   <= epsilon_next;
            max_terms_reg <= max_terms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        term_reg       <= term_next;
        sum_reg        <= sum_next;
        prod_reg       <= prod_next;
        used_reg       <= used_next;
        cap_reg        <= cap_next;
        exp_value_reg  <= exp_value_next;
        terms_used_reg <= terms_used_next;
        hit_cap_reg    <= hit_cap_next;
    end

    always_comb
    begin
        epsilon_next   = epsilon_reg;
        max_terms_next = max_terms_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ets_pkg::CFG_EPSILON:   epsilon_next   = cfg_data[EPS_W-1:0];
                ets_pkg::CFG_MAX_TERMS: max_terms_next = cfg_data[CAP_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        term_next       = term_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        used_next       = used_reg;
        cap_next        = cap_reg;
        exp_value_next  = exp_value_reg;
        terms_used_next = terms_used_reg;
        hit_cap_next    = hit_cap_reg;
        div_start       = 1'b0;

        unique case (state_reg)
            ets_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = x_value;
                    term_next = TERM_ONE;
                    sum_next  = SUM_ONE;
                    used_next = '0;
                    cap_next  = 1'b1;
                    if (max_terms_reg == '0)
                        state_next = ets_pkg::ST_FINAL;
                    else
                        state_next = ets_pkg::ST_MUL;
                end
            end
            ets_pkg::ST_MUL:
            begin
                prod_next  = term_reg * x_reg;
                state_next = ets_pkg::ST_DIV_LOAD;
            end
            ets_pkg::ST_DIV_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ets_pkg::ST_DIV_WAIT;
            end
            ets_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    term_next = prod_neg ? -$signed(quot) : $signed(quot);
                    sum_next  = prod_neg ? sum_reg - quot_ext : sum_reg + quot_ext;
                    used_next = CAP_W'(used_reg + CAP_W'(1));
                    if (quot <= eps_int)
                    begin
                        cap_next   = 1'b0;
                        state_next = ets_pkg::ST_FINAL;
                    end
                    else if (used_next >= max_terms_reg)
                        state_next = ets_pkg::ST_FINAL;
                    else
                        state_next = ets_pkg::ST_MUL;
                end
            end
            ets_pkg::ST_FINAL:
            begin
                if (sum_reg[SUM_W-1] || (sum_reg == '0))
                    exp_value_next = '0;
                else if (|sum_scaled[OUT_W-1:EXP_W])
                    exp_value_next = '1;
                else
                    exp_value_next = sum_scaled[EXP_W-1:0];
                terms_used_next = used_reg;
                hit_cap_next    = cap_reg;
                state_next      = ets_pkg::ST_OUT;
            end
            ets_pkg::ST_OUT:
            begin
                if (!out_stall)
                    state_next = ets_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ets_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ets_div.sv =====
// Iterative unsigned restoring divider that retires several quotient bits per cycle.
`timescale 1ns / 1ps

module ets_div #(
    parameter int DIVIDEND_W = 35,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP  = ets_pkg::DIV_BITS_PER_CYCLE;
    localparam int ITERS = (DIVIDEND_W + STEP - 1) / STEP;
    localparam int PAD_W = ITERS * STEP;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic [PAD_W-1:0]     shift_reg;
    logic [PAD_W-1:0]     shift_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] den_reg;
    logic [DIVISOR_W-1:0] den_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
    end

    always_comb
    begin
        logic [PAD_W-1:0]     sh;
        logic [DIVISOR_W-1:0] rem;
        logic [DIVISOR_W:0]   trial;

        sh         = shift_reg;
        rem        = rem_reg;
        trial      = '0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start)
        begin
            shift_next = PAD_W'(dividend);
            rem_next   = '0;
            den_next   = divisor;
            cnt_next   = CNT_W'(ITERS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < STEP; i++)
            begin
                trial = {rem, sh[PAD_W-1]};
                sh    = {sh[PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg})
                begin
                    trial = trial - {1'b0, den_reg};
                    sh[0] = 1'b1;
                end
                rem = trial[DIVISOR_W-1:0];
            end
            shift_next = sh;
            rem_next   = rem;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg[DIVIDEND_W-1:0];

endmodule
